### sv/bpfa_pkg.sv
package bpfa_pkg;

   // default sizing of the page map
   localparam int MAX_PAGES_DEFAULT     = 65536;
   localparam int MAP_WORD_BITS_DEFAULT = 64;

   // field widths
   localparam int OP_W       = 3;
   localparam int PAGE_IDX_W = 16;
   localparam int CNT_W      = 17;
   localparam int CNT_MAX    = (1 << CNT_W) - 1;

   // summary memory: one bit per map word, set when that word is full
   localparam int SUM_LOG  = 6;
   localparam int SUM_BITS = 1 << SUM_LOG;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_REQUEST   = 3'd0,
      OP_FREE      = 3'd1,
      OP_LOCK      = 3'd2,
      OP_RESERVE   = 3'd3,
      OP_UNRESERVE = 3'd4
   } op_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOCATE,
      ST_SEARCH,
      ST_MAP,
      ST_COMMIT
   } state_type;

   // saturating counter steps
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] value);
      sat_inc = (value == CNT_W'(CNT_MAX)) ? value : value + CNT_W'(1);
   endfunction

   function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] value);
      sat_dec = (value == '0) ? value : value - CNT_W'(1);
   endfunction

endpackage

### sv/bitmap_page_frame_allocator_top.sv
// Bitmap page frame allocator. One busy bit per physical page sits in a map memory of
// MAP_WORD_BITS-wide words; a summary memory holds one "word full" bit per map word and a
// small flop vector marks full summary words, so a request finds the lowest free page in
// a fixed walk: summary vector, summary word, map word. Every request (request, free,
// lock, reserve, unreserve) goes through locate or search, map and commit before the next
// acceptance, a walk set by the single-port read, modify and write-back of the map word;
// the response waits in an output register, and the next request runs up to its
// write-back while a stalled response is still held there. After reset, and after every
// write of page_count, the block clears both memories at one map word per cycle, walking
// all ceil(MAX_PAGES / MAP_WORD_BITS) map words, and holds req_stall high meanwhile;
// page_count is clamped to MAX_PAGES, counters saturate, a failed OP_REQUEST reports page 0.
module bitmap_page_frame_allocator_top #(
   parameter int MAX_PAGES     = bpfa_pkg::MAX_PAGES_DEFAULT,
   parameter int MAP_WORD_BITS = bpfa_pkg::MAP_WORD_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [bpfa_pkg::CNT_W-1:0]      csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [bpfa_pkg::OP_W-1:0]       req_operation,
   input  logic [bpfa_pkg::PAGE_IDX_W-1:0] req_page_index,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_success,
   output logic [bpfa_pkg::PAGE_IDX_W-1:0] rsp_page_out,
   output logic [bpfa_pkg::CNT_W-1:0]      rsp_free_pages,
   output logic [bpfa_pkg::CNT_W-1:0]      rsp_used_pages,
   output logic [bpfa_pkg::CNT_W-1:0]      rsp_reserved_pages
);
   import bpfa_pkg::*;

   localparam int MAP_WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int SUM_WORDS = (MAP_WORDS + SUM_BITS - 1) / SUM_BITS;
   localparam int SUM_AW    = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
   localparam int WX        = SUM_AW + SUM_LOG;
   localparam int BW        = $clog2(MAP_WORD_BITS);
   localparam int PW        = WX + BW;
   localparam int CW        = (PW > CNT_W) ? PW : CNT_W;
   localparam int RESET_LIM = (MAX_PAGES > CNT_MAX) ? CNT_MAX : MAX_PAGES;

   // memories
   logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [SUM_BITS-1:0]      sum_mem [SUM_WORDS];

   logic                     map_rd_en, map_wr_en;
   logic [WORD_AW-1:0]       map_addr;
   logic [MAP_WORD_BITS-1:0] map_wdata, map_rdata_ff;
   logic                     sum_rd_en, sum_wr_en;
   logic [SUM_AW-1:0]        sum_addr;
   logic [SUM_BITS-1:0]      sum_wdata, sum_rdata_ff;

   // control state
   state_type                state_ff, state_in;
   logic [WORD_AW-1:0]       clear_ptr_ff, clear_ptr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]         lim_ff, lim_in;
   logic [CNT_W-1:0]         free_ff, free_in;
   logic [CNT_W-1:0]         used_ff, used_in;
   logic [CNT_W-1:0]         resv_ff, resv_in;
   logic [SUM_WORDS-1:0]     group_full_ff, group_full_in;

   // per-request working registers
   logic [OP_W-1:0]          op_ff;
   logic [PAGE_IDX_W-1:0]    idx_ff;
   logic [SUM_AW-1:0]        grp_ff;
   logic                     grp_found_ff;
   logic [WX-1:0]            word_ff;
   logic                     hit_ff;
   logic                     ok_ff;
   logic [PAGE_IDX_W-1:0]    page_ff;
   logic [MAP_WORD_BITS-1:0] new_word_ff;
   logic                     rsp_success_ff;
   logic [PAGE_IDX_W-1:0]    rsp_page_ff;

   logic                     req_accept, rsp_accept, commit_go;
   logic                     grp_found, sum_found, map_found;
   logic [SUM_AW-1:0]        grp_idx;
   logic [SUM_LOG-1:0]       sum_bit;
   logic [BW-1:0]            map_bit;
   logic [WX-1:0]            loc_word, srch_word;
   logic                     loc_hit, srch_hit;
   logic [BW-1:0]            rem, bpos;
   logic [PW-1:0]            grant_page;
   logic [MAP_WORD_BITS-1:0] bit_mask, map_new;
   logic                     map_ok, op_set;
   logic [PAGE_IDX_W-1:0]    map_page;
   logic [SUM_BITS-1:0]      sum_new;
   logic [SUM_AW-1:0]        commit_grp;
   logic [CNT_W-1:0]         cfg_lim;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign commit_go  = (state_ff == ST_COMMIT) && (!rsp_valid_ff || !rsp_stall);

   // priority encoders: free group, non-full word, clear page bit
   bpfa_lzenc #(.WIDTH(SUM_WORDS)) u_grp_enc (
      .vec(group_full_ff), .found(grp_found), .idx(grp_idx)
   );
   bpfa_lzenc #(.WIDTH(SUM_BITS)) u_sum_enc (
      .vec(sum_rdata_ff), .found(sum_found), .idx(sum_bit)
   );
   bpfa_lzenc #(.WIDTH(MAP_WORD_BITS)) u_map_enc (
      .vec(map_rdata_ff), .found(map_found), .idx(map_bit)
   );

   // word of an indexed page
   assign loc_word   = WX'(idx_ff >> BW);
   assign loc_hit    = (op_ff == OP_FREE || op_ff == OP_LOCK || op_ff == OP_RESERVE ||
                        op_ff == OP_UNRESERVE) && (CNT_W'(idx_ff) < lim_ff);

   // word picked by the search
   assign srch_word = {grp_ff, sum_bit};
   assign srch_hit  = grp_found_ff && sum_found &&
                      ((WX + 1)'(srch_word) < (WX + 1)'(MAP_WORDS));

   // modify the map word
   assign rem        = idx_ff[BW-1:0] - BW'(word_ff) * BW'(MAP_WORD_BITS);
   assign grant_page = PW'(word_ff) * PW'(MAP_WORD_BITS) + PW'(map_bit);
   assign op_set     = (op_ff == OP_REQUEST || op_ff == OP_LOCK || op_ff == OP_RESERVE);
   assign bpos       = (op_ff == OP_REQUEST) ? map_bit : rem;
   assign bit_mask   = MAP_WORD_BITS'(1) << bpos;
   assign map_new    = op_set ? (map_rdata_ff | bit_mask) : (map_rdata_ff & ~bit_mask);

   always_comb begin
      if (op_ff == OP_REQUEST) begin
         map_ok   = hit_ff && map_found && (CW'(grant_page) < CW'(lim_ff));
         map_page = map_ok ? PAGE_IDX_W'(grant_page) : '0;
      end else begin
         map_ok   = hit_ff && (map_rdata_ff[bpos] != op_set);
         map_page = idx_ff;
      end
   end

   // summary word after the commit
   assign commit_grp = word_ff[WX-1:SUM_LOG];
   always_comb begin
      sum_new                         = sum_rdata_ff;
      sum_new[word_ff[SUM_LOG-1:0]]   = &new_word_ff;
   end

   // clamped page count from a configuration write
   assign cfg_lim = (CW'(csr_write_data) > CW'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : csr_write_data;

   // sequencer: next state and memory ports
   always_comb begin
      state_in      = state_ff;
      clear_ptr_in  = clear_ptr_ff;
      req_stall     = 1'b1;
      map_rd_en     = 1'b0;
      map_wr_en     = 1'b0;
      map_addr      = '0;
      map_wdata     = '0;
      sum_rd_en     = 1'b0;
      sum_wr_en     = 1'b0;
      sum_addr      = '0;
      sum_wdata     = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            map_wr_en    = 1'b1;
            map_addr     = clear_ptr_ff;
            sum_wr_en    = ({1'b0, clear_ptr_ff} < (WORD_AW + 1)'(SUM_WORDS));
            sum_addr     = clear_ptr_ff[SUM_AW-1:0];
            clear_ptr_in = clear_ptr_ff + WORD_AW'(1);
            if (clear_ptr_ff == WORD_AW'(MAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_operation == OP_REQUEST) begin
                  sum_rd_en = 1'b1;
                  sum_addr  = grp_idx;
                  state_in  = ST_SEARCH;
               end else begin
                  state_in = ST_LOCATE;
               end
            end
         end
         ST_LOCATE: begin
            map_rd_en = 1'b1;
            map_addr  = loc_word[WORD_AW-1:0];
            sum_rd_en = 1'b1;
            sum_addr  = loc_word[WX-1:SUM_LOG];
            state_in  = ST_MAP;
         end
         ST_SEARCH: begin
            map_rd_en = 1'b1;
            map_addr  = srch_word[WORD_AW-1:0];
            state_in  = ST_MAP;
         end
         ST_MAP: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit_go) begin
               map_wr_en = ok_ff;
               map_addr  = word_ff[WORD_AW-1:0];
               map_wdata = new_word_ff;
               sum_wr_en = ok_ff;
               sum_addr  = commit_grp;
               sum_wdata = sum_new;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
      if (csr_write_enable) begin
         state_in     = ST_CLEAR;
         clear_ptr_in = '0;
      end
   end

   // counters, limit, group flags and response valid
   always_comb begin
      lim_in        = lim_ff;
      free_in       = free_ff;
      used_in       = used_ff;
      resv_in       = resv_ff;
      group_full_in = group_full_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end
      if (commit_go) begin
         rsp_valid_in = 1'b1;
         if (ok_ff) begin
            group_full_in[commit_grp] = &sum_new;
            unique case (op_ff)
               OP_REQUEST, OP_LOCK: begin
                  free_in = sat_dec(free_ff);
                  used_in = sat_inc(used_ff);
               end
               OP_RESERVE: begin
                  free_in = sat_dec(free_ff);
                  resv_in = sat_inc(resv_ff);
               end
               OP_FREE: begin
                  free_in = sat_inc(free_ff);
                  used_in = sat_dec(used_ff);
               end
               OP_UNRESERVE: begin
                  free_in = sat_inc(free_ff);
                  resv_in = sat_dec(resv_ff);
               end
               default: ;
            endcase
         end
      end
      if (csr_write_enable) begin
         lim_in        = cfg_lim;
         free_in       = cfg_lim;
         used_in       = '0;
         resv_in       = '0;
         group_full_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_ptr_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         lim_ff        <= CNT_W'(RESET_LIM);
         free_ff       <= CNT_W'(RESET_LIM);
         used_ff       <= '0;
         resv_ff       <= '0;
         group_full_ff <= '0;
      end else begin
         state_ff      <= state_in;
         clear_ptr_ff  <= clear_ptr_in;
         rsp_valid_ff  <= rsp_valid_in;
         lim_ff        <= lim_in;
         free_ff       <= free_in;
         used_ff       <= used_in;
         resv_ff       <= resv_in;
         group_full_ff <= group_full_in;
      end
   end

   // working registers along the walk
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_ff        <= req_operation;
               idx_ff       <= req_page_index;
               grp_ff       <= grp_idx;
               grp_found_ff <= grp_found;
            end
         end
         ST_LOCATE: begin
            word_ff <= loc_word;
            hit_ff  <= loc_hit;
         end
         ST_SEARCH: begin
            word_ff <= srch_word;
            hit_ff  <= srch_hit;
         end
         ST_MAP: begin
            ok_ff       <= map_ok;
            page_ff     <= map_page;
            new_word_ff <= map_new;
         end
         default: ;
      endcase
      if (commit_go) begin
         rsp_success_ff <= ok_ff;
         rsp_page_ff    <= page_ff;
      end
   end

   // map memory
   always_ff @(posedge clock) begin
      if (map_wr_en) begin
         map_mem[map_addr] <= map_wdata;
      end
      if (map_rd_en) begin
         map_rdata_ff <= map_mem[map_addr];
      end
   end

   // summary memory
   always_ff @(posedge clock) begin
      if (sum_wr_en) begin
         sum_mem[sum_addr] <= sum_wdata;
      end
      if (sum_rd_en) begin
         sum_rdata_ff <= sum_mem[sum_addr];
      end
   end

   // response port; counters only move when a response is loaded or page_count is written
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_success        = rsp_success_ff;
   assign rsp_page_out       = rsp_page_ff;
   assign rsp_free_pages     = free_ff;
   assign rsp_used_pages     = used_ff;
   assign rsp_reserved_pages = resv_ff;

endmodule

### sv/bpfa_lzenc.sv
module bpfa_lzenc #(
   parameter int WIDTH = 8,
   localparam int IW = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
   input  logic [WIDTH-1:0] vec,
   output logic             found,
   output logic [IW-1:0]    idx
);

   // lowest clear bit wins
   always_comb begin
      found = 1'b0;
      idx   = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (!vec[i]) begin
            found = 1'b1;
            idx   = IW'(i);
         end
      end
   end

endmodule

### sv/bpfa_checker.sv
module bpfa_protocol_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            csr_write_enable,
   input logic [bpfa_pkg::CNT_W-1:0]      csr_write_data,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic [bpfa_pkg::OP_W-1:0]       req_operation,
   input logic [bpfa_pkg::PAGE_IDX_W-1:0] req_page_index,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_success,
   input logic [bpfa_pkg::PAGE_IDX_W-1:0] rsp_page_out,
   input logic [bpfa_pkg::CNT_W-1:0]      rsp_free_pages,
   input logic [bpfa_pkg::CNT_W-1:0]      rsp_used_pages,
   input logic [bpfa_pkg::CNT_W-1:0]      rsp_reserved_pages
);

   // clearing pass follows reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken straight after reset");

   // a page count write starts a clearing pass
   a_cfg_clears: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> req_stall)
      else $error("request taken straight after page count write");

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request taken while one is in flight");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_success) &&
         $stable(rsp_page_out) && $stable(rsp_free_pages) &&
         $stable(rsp_used_pages) && $stable(rsp_reserved_pages)))
      else $error("stalled response changed");

endmodule

bind bitmap_page_frame_allocator_top bpfa_protocol_checker u_bpfa_checker (.*);

### sim/bpfa_checker.sv
module bpfa_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [bpfa_pkg::CNT_W-1:0]      csr_write_data,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [bpfa_pkg::OP_W-1:0]       req_operation,
   input  logic [bpfa_pkg::PAGE_IDX_W-1:0] req_page_index,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_success,
   input  logic [bpfa_pkg::PAGE_IDX_W-1:0] rsp_page_out,
   input  logic [bpfa_pkg::CNT_W-1:0]      rsp_free_pages,
   input  logic [bpfa_pkg::CNT_W-1:0]      rsp_used_pages,
   input  logic [bpfa_pkg::CNT_W-1:0]      rsp_reserved_pages,
   output int                              mismatches,
   output int                              outstanding
);
   import bpfa_pkg::*;

   localparam int TOTAL_PAGES = MAX_PAGES_DEFAULT;
   localparam int WORD_BITS   = MAP_WORD_BITS_DEFAULT;
   localparam int MAP_WORDS   = (TOTAL_PAGES + WORD_BITS - 1) / WORD_BITS;

   typedef struct packed {
      logic                  success;
      logic [PAGE_IDX_W-1:0] page;
      logic [CNT_W-1:0]      free_pages;
      logic [CNT_W-1:0]      used_pages;
      logic [CNT_W-1:0]      reserved_pages;
   } alloc_outcome_type;

   // own copy of the busy map and the counters
   logic [WORD_BITS-1:0] frame_map [0:MAP_WORDS-1];
   int                   page_limit;
   logic [CNT_W-1:0]     free_cnt;
   logic [CNT_W-1:0]     used_cnt;
   logic [CNT_W-1:0]     rsvd_cnt;
   alloc_outcome_type    outcomes_due [$];
   int                   error_tally = 0;

   function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   function automatic logic [CNT_W-1:0] count_down(input logic [CNT_W-1:0] c);
      return (c == '0) ? c : c - 1'b1;
   endfunction

   // a page count write (or reset) clears the map and reloads the counters
   task automatic load_page_count(input logic [CNT_W-1:0] count);
      for (int w = 0; w < MAP_WORDS; w++) frame_map[w] = '0;
      page_limit = (int'(count) > TOTAL_PAGES) ? TOTAL_PAGES : int'(count);
      free_cnt   = CNT_W'(page_limit);
      used_cnt   = '0;
      rsvd_cnt   = '0;
   endtask

   // one operation on the map, returning the response it should produce
   function automatic alloc_outcome_type apply_frame_op(input logic [OP_W-1:0] op,
                                                        input logic [PAGE_IDX_W-1:0] idx);
      alloc_outcome_type res;
      logic              granted;
      logic              was_busy;
      logic              marking;
      int                w;
      int                b;
      granted  = 1'b0;
      res.page = idx;
      if (op == OP_REQUEST) begin
         // lowest clear page below the limit, skipping full words
         res.page = '0;
         for (w = 0; w < MAP_WORDS && !granted && w * WORD_BITS < page_limit; w++) begin
            if (frame_map[w] != '1) begin
               for (b = 0; b < WORD_BITS && !granted && w * WORD_BITS + b < page_limit;
                    b++) begin
                  if (!frame_map[w][b]) begin
                     frame_map[w][b] = 1'b1;
                     free_cnt = count_down(free_cnt);
                     used_cnt = count_up(used_cnt);
                     res.page = PAGE_IDX_W'(w * WORD_BITS + b);
                     granted  = 1'b1;
                  end
               end
            end
         end
      end else if (op <= OP_UNRESERVE && int'(idx) < page_limit) begin
         w        = int'(idx) / WORD_BITS;
         b        = int'(idx) % WORD_BITS;
         was_busy = frame_map[w][b];
         marking  = (op == OP_LOCK) || (op == OP_RESERVE);
         // only a change of the page's bit has any effect
         if (was_busy != marking) begin
            frame_map[w][b] = marking;
            granted         = 1'b1;
            if (marking) begin
               free_cnt = count_down(free_cnt);
               if (op == OP_LOCK) used_cnt = count_up(used_cnt);
               else rsvd_cnt = count_up(rsvd_cnt);
            end else begin
               free_cnt = count_up(free_cnt);
               if (op == OP_FREE) used_cnt = count_down(used_cnt);
               else rsvd_cnt = count_down(rsvd_cnt);
            end
         end
      end
      res.success        = granted;
      res.free_pages     = free_cnt;
      res.used_pages     = used_cnt;
      res.reserved_pages = rsvd_cnt;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                              input logic [CNT_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_tally++;
      end
   endtask

   // follow configuration, predict on each request, compare each response
   always @(posedge clock) begin
      alloc_outcome_type want;
      if (reset) begin
         load_page_count(CNT_W'(TOTAL_PAGES));
         outcomes_due.delete();
      end else begin
         if (csr_write_enable) load_page_count(csr_write_data);
         if (req_valid && !req_stall)
            outcomes_due.push_back(apply_frame_op(req_operation, req_page_index));
         if (rsp_valid && !rsp_stall) begin
            if (outcomes_due.size() == 0) begin
               $display("%0t: response with no request outstanding, page %0h", $time,
                        rsp_page_out);
               error_tally++;
            end else begin
               want = outcomes_due.pop_front();
               check_field("success", CNT_W'(want.success), CNT_W'(rsp_success));
               check_field("page_out", CNT_W'(want.page), CNT_W'(rsp_page_out));
               check_field("free_pages", want.free_pages, rsp_free_pages);
               check_field("used_pages", want.used_pages, rsp_used_pages);
               check_field("reserved_pages", want.reserved_pages, rsp_reserved_pages);
            end
         end
      end
      outstanding <= outcomes_due.size();
      mismatches  <= error_tally;
   end

endmodule

### sim/tb_bitmap_page_frame_allocator_top.sv
module tb_bitmap_page_frame_allocator_top;
   import bpfa_pkg::*;

   localparam int STALL_LIMIT = 5000;

   logic                  clock              = 1'b0;
   logic                  reset              = 1'b1;
   logic                  csr_write_enable   = 1'b0;
   logic [CNT_W-1:0]      csr_write_data     = '0;
   logic                  req_valid          = 1'b0;
   logic                  req_stall;
   logic [OP_W-1:0]       req_operation      = '0;
   logic [PAGE_IDX_W-1:0] req_page_index     = '0;
   logic                  rsp_valid;
   logic                  rsp_stall          = 1'b0;
   logic                  rsp_success;
   logic [PAGE_IDX_W-1:0] rsp_page_out;
   logic [CNT_W-1:0]      rsp_free_pages;
   logic [CNT_W-1:0]      rsp_used_pages;
   logic [CNT_W-1:0]      rsp_reserved_pages;

   int mismatches;
   int outstanding;
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int quiet_cycles  = 0;

   bitmap_page_frame_allocator_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_page_index     (req_page_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_success        (rsp_success),
      .rsp_page_out       (rsp_page_out),
      .rsp_free_pages     (rsp_free_pages),
      .rsp_used_pages     (rsp_used_pages),
      .rsp_reserved_pages (rsp_reserved_pages)
   );

   bpfa_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_page_index     (req_page_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_success        (rsp_success),
      .rsp_page_out       (rsp_page_out),
      .rsp_free_pages     (rsp_free_pages),
      .rsp_used_pages     (rsp_used_pages),
      .rsp_reserved_pages (rsp_reserved_pages),
      .mismatches         (mismatches),
      .outstanding        (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // random back-pressure on the response side
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
   end

   // watchdog on cycles where neither channel moves
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // one request, with a random gap in front, held until accepted
   task automatic send_request(input logic [OP_W-1:0] op, input logic [PAGE_IDX_W-1:0] idx);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_page_index <= idx;
      do @(posedge clock); while (req_stall);
   endtask

   // hold off until every response is back
   task automatic wait_drained;
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_page_count(input logic [CNT_W-1:0] count);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= count;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [OP_W-1:0] pick_op;
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return OP_REQUEST;
      if (r < 55) return OP_FREE;
      if (r < 70) return OP_LOCK;
      if (r < 83) return OP_RESERVE;
      if (r < 95) return OP_UNRESERVE;
      // codes past the last defined operation
      return OP_W'(OP_UNRESERVE) + OP_W'($urandom_range(1, 3));
   endfunction

   // mostly pages near the live range, with some anywhere and some at the top
   function automatic logic [PAGE_IDX_W-1:0] pick_index(input int limit);
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return PAGE_IDX_W'($urandom_range(0, 65535));
      if (r == 1) return PAGE_IDX_W'(65535 - $urandom_range(0, 2));
      if (limit <= 256) return PAGE_IDX_W'($urandom_range(0, limit + 1));
      return PAGE_IDX_W'($urandom_range(0, 160));
   endfunction

   function automatic int pick_page_count;
      case ($urandom_range(0, 9))
         0:       return 1;
         1:       return 64;
         2:       return 65;
         7:       return MAX_PAGES_DEFAULT;
         8:       return CNT_MAX;
         9:       return $urandom_range(1, MAX_PAGES_DEFAULT);
         default: return $urandom_range(2, 120);
      endcase
   endfunction

   initial begin
      int count;
      int limit;
      send_idle_pct = 18;
      rsp_idle_pct  = 81;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: grants, no-change cases, bad codes
      send_request(OP_REQUEST, 16'hFFFF);
      send_request(OP_REQUEST, 16'h0000);
      send_request(OP_FREE, 16'h0000);
      send_request(OP_FREE, 16'h0000);
      send_request(OP_REQUEST, 16'h0000);
      send_request(OP_LOCK, 16'hFFFF);
      send_request(OP_RESERVE, 16'hFFFF);
      send_request(OP_UNRESERVE, 16'hFFFF);
      send_request(OP_RESERVE, 16'h0002);
      send_request(OP_REQUEST, 16'h0000);
      send_request(OP_UNRESERVE, 16'h0002);
      send_request(OP_W'(OP_UNRESERVE) + OP_W'(1), 16'hA5A5);
      send_request(OP_W'(OP_UNRESERVE) + OP_W'(2), 16'h5A5A);
      send_request(OP_W'(OP_UNRESERVE) + OP_W'(3), 16'h0001);
      // single page: exhaustion and out of range index
      write_page_count(CNT_W'(1));
      send_request(OP_REQUEST, 16'h0000);
      send_request(OP_REQUEST, 16'h0000);
      send_request(OP_LOCK, 16'h0001);
      send_request(OP_FREE, 16'h0000);
      // no pages managed at all
      write_page_count('0);
      send_request(OP_REQUEST, 16'h0000);
      send_request(OP_LOCK, 16'h0000);
      // oversize count is clamped to the map size
      write_page_count(CNT_W'(CNT_MAX));
      send_request(OP_LOCK, 16'hFFFF);
      send_request(OP_REQUEST, 16'h0000);

      // random: three idling phases, each with three page count settings
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 81 : 0;
         rsp_idle_pct  = (phase == 0) ? 81 : (phase == 1) ? 18 : 0;
         for (int chunk = 0; chunk < 3; chunk++) begin
            count = (phase == 0 && chunk == 0) ? MAX_PAGES_DEFAULT : pick_page_count();
            limit = (count > MAX_PAGES_DEFAULT) ? MAX_PAGES_DEFAULT : count;
            write_page_count(CNT_W'(count));
            for (int i = 0; i < 100; i++) begin
               if (phase == 1 && chunk == 1 && i == 50) wait_drained();
               send_request(pick_op(), pick_index(limit));
            end
         end
      end

      wait_drained();
      repeat (16) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
